### rtl/barometric_pressure_compensation_unit_defines.svh
// Assertion helpers for the compensation unit.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// Implication in the same cycle, off during reset.
`define BPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpc: implication check failed");

// Consequent a fixed number of cycles after the antecedent.
`define BPC_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("bpc: delayed check failed");

`endif

### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Register map, reset values and fixed coefficients of the compensation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    typedef enum logic [2:0] {
        REG_AC1   = 3'd0,
        REG_AC2   = 3'd1,
        REG_AC3   = 3'd2,
        REG_AC4   = 3'd3,
        REG_AC5   = 3'd4,
        REG_AC6   = 3'd5,
        REG_BPAIR = 3'd6,
        REG_MPAIR = 3'd7
    } t_reg_idx;

    localparam logic [15:0] RST_AC1   = 16'd408;
    localparam logic [15:0] RST_AC2   = 16'hFFB8;
    localparam logic [15:0] RST_AC3   = 16'hC7D1;
    localparam logic [15:0] RST_AC4   = 16'd32741;
    localparam logic [15:0] RST_AC5   = 16'd32757;
    localparam logic [15:0] RST_AC6   = 16'd23153;
    localparam logic [31:0] RST_BPAIR = 32'd405667844;
    localparam logic [31:0] RST_MPAIR = 32'd3724086068;

    localparam logic signed [27:0] B6_OFFSET  = 28'sd4000;
    localparam logic [31:0]        B4_OFFSET  = 32'd32768;
    localparam logic [15:0]        P_SCALE    = 16'd50000;
    localparam logic [11:0]        P_C1       = 12'd3038;
    localparam logic signed [13:0] P_C2       = -14'sd7357;
    localparam logic signed [44:0] P_C3       = 45'sd3791;
    localparam logic [17:0]        PRES_MAX   = 18'd262143;

endpackage

`default_nettype wire

### rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div #(
    parameter int N = 32,
    parameter int M = 17,
    parameter int W = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [N-1:0] i_dividend,
    input  wire logic [M-1:0] i_divisor,
    input  wire logic [W-1:0] i_side,
    output logic              o_valid,
    output logic [N-1:0]      o_quotient,
    output logic [W-1:0]      o_side
);

    logic         r_vld  [N];
    logic [M-1:0] r_rem  [N];
    logic [M-1:0] r_div  [N];
    logic [N-1:0] r_dvd  [N];
    logic [N-1:0] r_quo  [N];
    logic [W-1:0] r_side [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic         c_vld;
        logic [M-1:0] c_rem;
        logic [M-1:0] c_div;
        logic [N-1:0] c_dvd;
        logic [N-1:0] c_quo;
        logic [W-1:0] c_side;
        logic [M:0]   n_trial;
        logic [M:0]   n_diff;
        logic         n_ge;

        assign c_vld  = (i == 0) ? i_valid    : r_vld[(i == 0) ? 0 : i - 1];
        assign c_rem  = (i == 0) ? '0         : r_rem[(i == 0) ? 0 : i - 1];
        assign c_div  = (i == 0) ? i_divisor  : r_div[(i == 0) ? 0 : i - 1];
        assign c_dvd  = (i == 0) ? i_dividend : r_dvd[(i == 0) ? 0 : i - 1];
        assign c_quo  = (i == 0) ? '0         : r_quo[(i == 0) ? 0 : i - 1];
        assign c_side = (i == 0) ? i_side     : r_side[(i == 0) ? 0 : i - 1];

        // bring down the next dividend bit and try a subtract
        assign n_trial = {c_rem, c_dvd[N-1]};
        assign n_diff  = n_trial - {1'b0, c_div};
        assign n_ge    = (n_trial >= {1'b0, c_div});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[i]  <= n_ge ? n_diff[M-1:0] : n_trial[M-1:0];
            r_div[i]  <= c_div;
            r_dvd[i]  <= {c_dvd[N-2:0], 1'b0};
            r_quo[i]  <= {c_quo[N-2:0], n_ge};
            r_side[i] <= c_side;
        end
    end

    assign o_valid    = r_vld[N-1];
    assign o_quotient = r_quo[N-1];
    assign o_side     = r_side[N-1];

endmodule

`default_nettype wire

### rtl/barometric_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Fixed-point temperature and pressure compensation from calibration words.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse start with a raw temperature and raw pressure word; the pair
//   is taken at any edge with start high and busy low. busy stays low, so a
//   new pair may enter every cycle.
//   Output: each result shows on the o_ ports for one cycle with o_done high.
//   The receiver cannot stall; the pipeline never holds.
//   Throughput: one transaction per clock. Latency is set by the two bit-serial
//   pipelined dividers (27 and 32 stages) plus 21 arithmetic stages.
//   Configuration: APB write, register i at byte address 4*i; pready is high.
//   Write calibration only while no transaction is in flight.
//   A zero divisor raises o_divide_error and forces both results to zero.
//   Reset: synchronous, active low; clears all valid bits and restores the
//   calibration words to their factory defaults. Results in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "barometric_pressure_compensation_unit_defines.svh"

module barometric_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        i_raw_temperature,
    input  wire logic [15:0]        i_raw_pressure,
    output logic                    o_done,
    output logic signed [15:0]      o_temperature_tenths,
    output logic [17:0]             o_pressure_pascal,
    output logic                    o_divide_error,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int DIV1_N  = 27;
    localparam int DIV1_M  = 18;
    localparam int DIV1_W  = 36;
    localparam int DIV2_N  = 32;
    localparam int DIV2_M  = 17;
    localparam int DIV2_W  = 18;
    localparam int LATENCY = 3 + DIV1_N + 11 + DIV2_N + 7;

    // ---------------- configuration ----------------
    logic [15:0] r_ac1, r_ac2, r_ac3, r_ac4, r_ac5, r_ac6;
    logic [31:0] r_bpair, r_mpair;
    logic        n_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1   <= RST_AC1;
            r_ac2   <= RST_AC2;
            r_ac3   <= RST_AC3;
            r_ac4   <= RST_AC4;
            r_ac5   <= RST_AC5;
            r_ac6   <= RST_AC6;
            r_bpair <= RST_BPAIR;
            r_mpair <= RST_MPAIR;
        end else if (n_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_AC1:   r_ac1   <= pwdata[15:0];
                REG_AC2:   r_ac2   <= pwdata[15:0];
                REG_AC3:   r_ac3   <= pwdata[15:0];
                REG_AC4:   r_ac4   <= pwdata[15:0];
                REG_AC5:   r_ac5   <= pwdata[15:0];
                REG_AC6:   r_ac6   <= pwdata[15:0];
                REG_BPAIR: r_bpair <= pwdata;
                REG_MPAIR: r_mpair <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_AC1:   prdata = {16'd0, r_ac1};
            REG_AC2:   prdata = {16'd0, r_ac2};
            REG_AC3:   prdata = {16'd0, r_ac3};
            REG_AC4:   prdata = {16'd0, r_ac4};
            REG_AC5:   prdata = {16'd0, r_ac5};
            REG_AC6:   prdata = {16'd0, r_ac6};
            REG_BPAIR: prdata = r_bpair;
            REG_MPAIR: prdata = r_mpair;
        endcase
    end

    logic signed [15:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    assign w_ac1 = r_ac1;
    assign w_ac2 = r_ac2;
    assign w_ac3 = r_ac3;
    assign w_b1  = r_bpair[31:16];
    assign w_b2  = r_bpair[15:0];
    assign w_mc  = r_mpair[31:16];
    assign w_md  = r_mpair[15:0];

    // ---------------- s1..s3: temperature term and divisor ----------------
    logic               r_s1_vld, r_s2_vld, r_s3_vld;
    logic signed [16:0] r_s1_diff;
    logic [15:0]        r_s1_up, r_s2_up, r_s3_up;
    logic signed [33:0] r_s2_prod;
    logic signed [17:0] r_s3_x1;
    logic signed [18:0] r_s3_den;
    logic signed [33:0] n_s3_bias;
    logic signed [17:0] n_s3_x1;

    assign n_s3_bias = r_s2_prod + (r_s2_prod[33] ? 34'sd32767 : 34'sd0);
    assign n_s3_x1   = n_s3_bias[32:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_diff <= $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_ac6});
        r_s1_up   <= i_raw_pressure;
        r_s2_prod <= r_s1_diff * $signed({1'b0, r_ac5});
        r_s2_up   <= r_s1_up;
        r_s3_x1   <= n_s3_x1;
        r_s3_den  <= 19'(n_s3_x1) + 19'(w_md);
        r_s3_up   <= r_s2_up;
    end

    // sign and magnitude for the first divider
    logic [15:0]       n_mc_mag;
    logic [18:0]       n_den_abs;
    logic [DIV1_N-1:0] n_d1_dvd;
    logic [DIV1_W-1:0] n_d1_side;
    logic              d1_vld;
    logic [DIV1_N-1:0] d1_quo;
    logic [DIV1_W-1:0] d1_side;

    assign n_mc_mag  = w_mc[15] ? (~r_mpair[31:16] + 16'd1) : r_mpair[31:16];
    assign n_den_abs = r_s3_den[18] ? (~r_s3_den + 19'd1) : r_s3_den;
    assign n_d1_dvd  = {n_mc_mag, 11'd0};
    assign n_d1_side = {r_s3_x1, r_s3_up, w_mc[15] ^ r_s3_den[18], (r_s3_den == 19'sd0)};

    bpc_div #(.N(DIV1_N), .M(DIV1_M), .W(DIV1_W)) u_div_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s3_vld),
        .i_dividend (n_d1_dvd),
        .i_divisor  (n_den_abs[DIV1_M-1:0]),
        .i_side     (n_d1_side),
        .o_valid    (d1_vld),
        .o_quotient (d1_quo),
        .o_side     (d1_side)
    );

    // ---------------- s4..s14: pressure coefficients ----------------
    logic signed [17:0] n_s4_x1;
    logic signed [27:0] n_s4_x2;
    assign n_s4_x1 = d1_side[35:18];
    assign n_s4_x2 = d1_side[1] ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});

    logic               r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld, r_s9_vld;
    logic               r_s10_vld, r_s11_vld, r_s12_vld, r_s13_vld, r_s14_vld;
    logic signed [27:0] r_s4_b5, r_s5_b6;
    logic [15:0]        r_s4_up, r_s5_up, r_s6_up, r_s7_up, r_s8_up, r_s9_up;
    logic [15:0]        r_s10_up, r_s11_up, r_s12_up;
    logic               r_s4_err, r_s5_err, r_s6_err, r_s7_err, r_s8_err, r_s9_err;
    logic               r_s10_err, r_s11_err, r_s12_err, r_s13_err, r_s14_err;
    logic signed [15:0] r_s5_t, r_s6_t, r_s7_t, r_s8_t, r_s9_t, r_s10_t;
    logic signed [15:0] r_s11_t, r_s12_t, r_s13_t, r_s14_t;

    // temperature: (b5 + 8) / 16 toward zero, then saturate
    logic signed [27:0] n_s5_v, n_s5_vb;
    logic signed [23:0] n_s5_tr;
    logic signed [15:0] n_s5_t;
    assign n_s5_v  = r_s4_b5 + 28'sd8;
    assign n_s5_vb = n_s5_v + (n_s5_v[27] ? 28'sd15 : 28'sd0);
    assign n_s5_tr = n_s5_vb[27:4];
    always_comb begin
        if (n_s5_tr > 24'sd32767) begin
            n_s5_t = 16'sh7FFF;
        end else if (n_s5_tr < -24'sd32768) begin
            n_s5_t = 16'sh8000;
        end else begin
            n_s5_t = n_s5_tr[15:0];
        end
    end

    logic signed [55:0] n_s6_sq;
    logic [53:0]        r_s6_sqf;
    logic signed [43:0] r_s6_m2, r_s6_m3;
    assign n_s6_sq = r_s5_b6 * r_s5_b6;

    logic signed [43:0] n_s7_m2b, n_s7_m3b;
    logic [41:0]        r_s7_sq;
    logic signed [31:0] r_s7_x2a, r_s8_x2a, r_s9_x2a, r_s10_x2a;
    logic signed [29:0] r_s7_x1b, r_s8_x1b, r_s9_x1b, r_s10_x1b;
    assign n_s7_m2b = r_s6_m2 + (r_s6_m2[43] ? 44'sd2047 : 44'sd0);
    assign n_s7_m3b = r_s6_m3 + (r_s6_m3[43] ? 44'sd8191 : 44'sd0);

    // split sq in halves so each product stays narrow
    logic signed [37:0] r_s8_p2l, r_s8_p2h, r_s8_p1l, r_s8_p1h;
    logic signed [57:0] r_s9_b2sq, r_s9_b1sq;
    logic signed [57:0] n_s10_b2b, n_s10_b1b;
    logic signed [45:0] r_s10_x1a;
    logic signed [40:0] r_s10_x2b;
    assign n_s10_b2b = r_s9_b2sq + (r_s9_b2sq[57] ? 58'sd2047 : 58'sd0);
    assign n_s10_b1b = r_s9_b1sq + (r_s9_b1sq[57] ? 58'sd65535 : 58'sd0);

    logic signed [47:0] r_s11_num, n_s12_numb;
    logic signed [41:0] r_s11_n3, n_s12_n3b;
    logic [31:0]        r_s12_b3lo, r_s12_x3lo;
    assign n_s12_numb = r_s11_num + (r_s11_num[47] ? 48'sd3 : 48'sd0);
    assign n_s12_n3b  = r_s11_n3 + (r_s11_n3[41] ? 42'sd3 : 42'sd0);

    logic [31:0] r_s13_pb, r_s13_sb, r_s14_b4f, r_s14_b7;
    logic [47:0] n_s14_b4p, n_s14_b7p;
    assign n_s14_b4p = r_ac4 * r_s13_sb;
    assign n_s14_b7p = r_s13_pb * P_SCALE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            r_s14_vld <= 1'b0;
        end else begin
            r_s4_vld  <= d1_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
            r_s14_vld <= r_s13_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_b5    <= n_s4_x2 + 28'(n_s4_x1);
        r_s4_up    <= d1_side[17:2];
        r_s4_err   <= d1_side[0];

        r_s5_b6    <= r_s4_b5 - B6_OFFSET;
        r_s5_t     <= n_s5_t;
        r_s5_up    <= r_s4_up;
        r_s5_err   <= r_s4_err;

        r_s6_sqf   <= n_s6_sq[53:0];
        r_s6_m2    <= r_s5_b6 * w_ac2;
        r_s6_m3    <= r_s5_b6 * w_ac3;
        r_s6_t     <= r_s5_t;
        r_s6_up    <= r_s5_up;
        r_s6_err   <= r_s5_err;

        r_s7_sq    <= r_s6_sqf[53:12];
        r_s7_x2a   <= n_s7_m2b[42:11];
        r_s7_x1b   <= n_s7_m3b[42:13];
        r_s7_t     <= r_s6_t;
        r_s7_up    <= r_s6_up;
        r_s7_err   <= r_s6_err;

        r_s8_p2l   <= w_b2 * $signed({1'b0, r_s7_sq[20:0]});
        r_s8_p2h   <= w_b2 * $signed({1'b0, r_s7_sq[41:21]});
        r_s8_p1l   <= w_b1 * $signed({1'b0, r_s7_sq[20:0]});
        r_s8_p1h   <= w_b1 * $signed({1'b0, r_s7_sq[41:21]});
        r_s8_x2a   <= r_s7_x2a;
        r_s8_x1b   <= r_s7_x1b;
        r_s8_t     <= r_s7_t;
        r_s8_up    <= r_s7_up;
        r_s8_err   <= r_s7_err;

        r_s9_b2sq  <= $signed({r_s8_p2h[36:0], 21'd0}) + 58'(r_s8_p2l);
        r_s9_b1sq  <= $signed({r_s8_p1h[36:0], 21'd0}) + 58'(r_s8_p1l);
        r_s9_x2a   <= r_s8_x2a;
        r_s9_x1b   <= r_s8_x1b;
        r_s9_t     <= r_s8_t;
        r_s9_up    <= r_s8_up;
        r_s9_err   <= r_s8_err;

        r_s10_x1a  <= n_s10_b2b[56:11];
        r_s10_x2b  <= n_s10_b1b[56:16];
        r_s10_x2a  <= r_s9_x2a;
        r_s10_x1b  <= r_s9_x1b;
        r_s10_t    <= r_s9_t;
        r_s10_up   <= r_s9_up;
        r_s10_err  <= r_s9_err;

        r_s11_num  <= 48'(r_s10_x1a) + 48'(r_s10_x2a) + 48'($signed({w_ac1, 2'b00}))
                      + 48'sd2;
        r_s11_n3   <= 42'(r_s10_x1b) + 42'(r_s10_x2b) + 42'sd2;
        r_s11_t    <= r_s10_t;
        r_s11_up   <= r_s10_up;
        r_s11_err  <= r_s10_err;

        r_s12_b3lo <= n_s12_numb[33:2];
        r_s12_x3lo <= n_s12_n3b[33:2];
        r_s12_t    <= r_s11_t;
        r_s12_up   <= r_s11_up;
        r_s12_err  <= r_s11_err;

        r_s13_pb   <= {16'd0, r_s12_up} - r_s12_b3lo;
        r_s13_sb   <= r_s12_x3lo + B4_OFFSET;
        r_s13_t    <= r_s12_t;
        r_s13_err  <= r_s12_err;

        r_s14_b4f  <= n_s14_b4p[31:0];
        r_s14_b7   <= n_s14_b7p[31:0];
        r_s14_t    <= r_s13_t;
        r_s14_err  <= r_s13_err;
    end

    // ---------------- pressure quotient ----------------
    logic [DIV2_N-1:0] n_d2_dvd;
    logic [DIV2_M-1:0] n_d2_div;
    logic [DIV2_W-1:0] n_d2_side;
    logic              d2_vld;
    logic [DIV2_N-1:0] d2_quo;
    logic [DIV2_W-1:0] d2_side;

    // below half range, double before dividing; else double the quotient
    assign n_d2_div  = r_s14_b4f[31:15];
    assign n_d2_dvd  = r_s14_b7[31] ? r_s14_b7 : {r_s14_b7[30:0], 1'b0};
    assign n_d2_side = {r_s14_t, r_s14_err | (n_d2_div == '0), r_s14_b7[31]};

    bpc_div #(.N(DIV2_N), .M(DIV2_M), .W(DIV2_W)) u_div_pres (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s14_vld),
        .i_dividend (n_d2_dvd),
        .i_divisor  (n_d2_div),
        .i_side     (n_d2_side),
        .o_valid    (d2_vld),
        .o_quotient (d2_quo),
        .o_side     (d2_side)
    );

    // ---------------- s15..s20: final pressure correction ----------------
    logic               r_s15_vld, r_s16_vld, r_s17_vld, r_s18_vld, r_s19_vld, r_s20_vld;
    logic signed [31:0] r_s15_p, r_s16_p, r_s17_p, r_s18_p, r_s19_p;
    logic signed [15:0] r_s15_t, r_s16_t, r_s17_t, r_s18_t, r_s19_t, r_s20_t;
    logic               r_s15_err, r_s16_err, r_s17_err, r_s18_err, r_s19_err, r_s20_err;

    logic signed [31:0] n_s16_pb;
    logic signed [23:0] r_s16_pd;
    logic signed [45:0] r_s16_m, n_s17_mb;
    logic [46:0]        r_s17_sqp;
    logic signed [47:0] n_s17_sq;
    logic signed [28:0] r_s17_x2, r_s18_x2;
    logic [58:0]        r_s18_m1;
    logic signed [44:0] r_s19_sum, n_s20_sb;
    logic signed [40:0] n_s20_div;
    logic signed [41:0] r_s20_pf;

    assign n_s16_pb  = r_s15_p + (r_s15_p[31] ? 32'sd255 : 32'sd0);
    assign n_s17_sq  = r_s16_pd * r_s16_pd;
    assign n_s17_mb  = r_s16_m + (r_s16_m[45] ? 46'sd65535 : 46'sd0);
    assign n_s20_sb  = r_s19_sum + (r_s19_sum[44] ? 45'sd15 : 45'sd0);
    assign n_s20_div = n_s20_sb[44:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s15_vld <= 1'b0;
            r_s16_vld <= 1'b0;
            r_s17_vld <= 1'b0;
            r_s18_vld <= 1'b0;
            r_s19_vld <= 1'b0;
            r_s20_vld <= 1'b0;
        end else begin
            r_s15_vld <= d2_vld;
            r_s16_vld <= r_s15_vld;
            r_s17_vld <= r_s16_vld;
            r_s18_vld <= r_s17_vld;
            r_s19_vld <= r_s18_vld;
            r_s20_vld <= r_s19_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s15_p   <= d2_side[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
        r_s15_t   <= d2_side[17:2];
        r_s15_err <= d2_side[1];

        r_s16_pd  <= n_s16_pb[31:8];
        r_s16_m   <= r_s15_p * P_C2;
        r_s16_p   <= r_s15_p;
        r_s16_t   <= r_s15_t;
        r_s16_err <= r_s15_err;

        r_s17_sqp <= n_s17_sq[46:0];
        r_s17_x2  <= n_s17_mb[44:16];
        r_s17_p   <= r_s16_p;
        r_s17_t   <= r_s16_t;
        r_s17_err <= r_s16_err;

        r_s18_m1  <= r_s17_sqp * P_C1;
        r_s18_x2  <= r_s17_x2;
        r_s18_p   <= r_s17_p;
        r_s18_t   <= r_s17_t;
        r_s18_err <= r_s17_err;

        r_s19_sum <= $signed({2'b00, r_s18_m1[58:16]}) + 45'(r_s18_x2) + P_C3;
        r_s19_p   <= r_s18_p;
        r_s19_t   <= r_s18_t;
        r_s19_err <= r_s18_err;

        r_s20_pf  <= 42'(r_s19_p) + 42'(n_s20_div);
        r_s20_t   <= r_s19_t;
        r_s20_err <= r_s19_err;
    end

    // ---------------- output register ----------------
    logic [17:0]        n_out_p;
    logic               r_out_done;
    logic signed [15:0] r_out_t;
    logic [17:0]        r_out_p;
    logic               r_out_err;

    always_comb begin
        if (r_s20_err || r_s20_pf[41]) begin
            n_out_p = '0;
        end else if (r_s20_pf > 42'sd262143) begin
            n_out_p = PRES_MAX;
        end else begin
            n_out_p = r_s20_pf[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_done <= 1'b0;
        end else begin
            r_out_done <= r_s20_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_t   <= r_s20_err ? 16'sd0 : r_s20_t;
        r_out_p   <= n_out_p;
        r_out_err <= r_s20_err;
    end

    assign o_done               = r_out_done;
    assign o_temperature_tenths = r_out_t;
    assign o_pressure_pascal    = r_out_p;
    assign o_divide_error       = r_out_err;

    // ---------------- assertions ----------------
    `BPC_ASSERT_DELAY(a_latency, start && !busy, LATENCY, o_done)
    `BPC_ASSERT_IMPL(a_no_orphan, o_done, $past(start, LATENCY))
    `BPC_ASSERT_IMPL(a_err_zero, o_done && o_divide_error,
                     o_temperature_tenths == 16'sd0 && o_pressure_pascal == 18'd0)

endmodule

`default_nettype wire
